// ===== rtl/rces_pkg.sv =====
// rces_pkg: register indexes, map selection codes and the tag word shared by
// the channel shaper top level and its mapping divider. No dependencies.
`timescale 1ns / 1ps

package rces_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int EXPO_W    = 7;
	localparam int GAIN_W    = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANALOG_MODE    = 3'd0,
		REG_ADC_MIN        = 3'd1,
		REG_ADC_MAX        = 3'd2,
		REG_REVERSE_DIR    = 3'd3,
		REG_EXPO_PERCENT   = 3'd4,
		REG_USE_LOW_RATE   = 3'd5,
		REG_LOW_RATE_GAIN  = 3'd6,
		REG_HIGH_RATE_GAIN = 3'd7
	} reg_idx_t;

	localparam logic [EXPO_W-1:0] EXPO_CAP = 7'd100;
	localparam logic [GAIN_W-1:0] GAIN_MIN = 10'd256;

	// how the raw value is formed once the quotient is known
	typedef enum logic [1:0] {
		MAP_DIV  = 2'd0,
		MAP_ONE  = 2'd1,
		MAP_MONE = 2'd2,
		MAP_ZERO = 2'd3
	} map_sel_t;

	typedef struct packed {
		map_sel_t sel;
		logic     analog;
		logic     reverse;
	} map_tag_t;

endpackage

// ===== rtl/rces_div.sv =====
// rces_div: pipelined restoring divider for the linear ADC map, one quotient
// bit per stage after an overflow check. Depends on rces_pkg.
`timescale 1ns / 1ps

module rces_div #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 13,
	parameter int Q_W   = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 num_valid,
	output logic                 num_ready,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	input  rces_pkg::map_tag_t   tag,
	output logic                 quot_valid,
	input  logic                 quot_ready,
	output logic [Q_W-1:0]       quot,
	output logic                 sat,
	output rces_pkg::map_tag_t   quot_tag
);

	localparam int NS = Q_W + 1;

	logic [NS-1:0]      v_s;
	logic [NS:0]        en;
	logic [NUM_W-1:0]   rem_s [Q_W];
	logic [DEN_W-1:0]   den_s [Q_W];
	logic [Q_W-1:0]     q_s   [NS];
	logic               sat_s [NS];
	rces_pkg::map_tag_t tag_s [NS];

	assign en[NS] = quot_ready;

	genvar j;
	generate
		for (j = 0; j < NS; j++) begin : g_en
			assign en[j] = !v_s[j] || en[j+1];
		end
	endgenerate

	// overflow check: quotient of 2**Q_W or more saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= num_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			sat_s[0] <= (num >= (NUM_W'(den) << Q_W));
			tag_s[0] <= tag;
		end
	end

	generate
		for (j = 1; j < NS; j++) begin : g_stage
			logic [NUM_W-1:0] dsh;
			logic             ge;

			assign dsh = NUM_W'(den_s[j-1]) << (Q_W - j);
			assign ge  = (rem_s[j-1] >= dsh);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j] <= 1'b0;
				end else if (en[j]) begin
					v_s[j] <= v_s[j-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[j]) begin
					q_s[j]   <= q_s[j-1] | (Q_W'(ge) << (Q_W - j));
					sat_s[j] <= sat_s[j-1];
					tag_s[j] <= tag_s[j-1];
				end
			end

			if (j < Q_W) begin : g_rem
				always_ff @(posedge clk) begin
					if (en[j]) begin
						rem_s[j] <= ge ? (rem_s[j-1] - dsh) : rem_s[j-1];
						den_s[j] <= den_s[j-1];
					end
				end
			end
		end
	endgenerate

	assign num_ready  = en[0];
	assign quot_valid = v_s[NS-1];
	assign quot       = q_s[NS-1];
	assign sat        = sat_s[NS-1];
	assign quot_tag   = tag_s[NS-1];

endmodule

// ===== rtl/rc_channel_expo_rate_shaper_top.sv =====
// rc_channel_expo_rate_shaper_top: RC channel map, reverse, expo and rate
// pipeline with its configuration registers. Depends on rces_pkg, rces_div.
//
// Usage: one ADC sample word enters on sample_valid/sample_ready and one
// result word (raw_value, reversed_value, shaped_value, signed with
// FRAC_BITS fraction bits) leaves on result_valid/result_ready.
// Registers are written through cfg_write/cfg_index/cfg_data, one per cycle;
// the user must write them only while no word is in flight, since the block
// itself does not enforce this. Throughput: one word per cycle while the
// receiver keeps result_ready high. The divider of the linear map resolves
// one quotient bit per stage, and the cubic term uses two chained multiplies.
// Reset: all stages empty, registers at their defaults (analog mode, full
// ADC span, no reverse, no expo, unity gains).
// Stall: every stage has its own valid bit and holds while the next stage
// is full, so sample_ready stays high until the whole pipeline is full
// behind a stalled receiver; nothing is dropped or repeated.
`timescale 1ns / 1ps

module rc_channel_expo_rate_shaper_top #(
	parameter int ADC_BITS  = 12,
	parameter int FRAC_BITS = 14
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        sample_valid,
	output logic                                        sample_ready,
	input  logic [ADC_BITS-1:0]                         sample,
	output logic                                        result_valid,
	input  logic                                        result_ready,
	output logic signed [FRAC_BITS+1:0]                 raw_value,
	output logic signed [FRAC_BITS+1:0]                 reversed_value,
	output logic signed [FRAC_BITS+1:0]                 shaped_value,
	input  logic                                        cfg_write,
	input  logic [rces_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [((ADC_BITS > rces_pkg::GAIN_W) ? ADC_BITS : rces_pkg::GAIN_W)-1:0] cfg_data
);

	localparam int OW       = FRAC_BITS + 2;
	localparam int MW       = FRAC_BITS + 1;
	localparam int NUM_W    = ADC_BITS + FRAC_BITS + 3;
	localparam int DEN_W    = ADC_BITS + 1;
	localparam int ED_W     = OW + 8;
	localparam int ND_W     = FRAC_BITS + 7;
	localparam int RECIP_W  = ND_W - 6;
	localparam int PW       = ND_W + RECIP_W;
	localparam int GP_W     = OW + rces_pkg::GAIN_W + 1;
	localparam int RN_W     = FRAC_BITS + 3;

	localparam logic signed [OW-1:0] Q_ONE  = OW'(longint'(1) << FRAC_BITS);
	localparam logic signed [OW-1:0] Q_HALF = OW'(longint'(1) << (FRAC_BITS - 1));
	localparam logic signed [OW-1:0] S_MIN  = {1'b1, {(OW-1){1'b0}}};
	localparam logic signed [OW-1:0] S_MAX  = {1'b0, {(OW-1){1'b1}}};
	localparam logic [2*MW-1:0]      RND_HALF = (2*MW)'(longint'(1) << (FRAC_BITS - 1));
	localparam logic [RECIP_W-1:0]   RECIP  = RECIP_W'((longint'(1) << ND_W) / 100);
	localparam logic [RN_W-1:0]      RN_TWO = RN_W'(longint'(1) << (FRAC_BITS + 1));

	// configuration registers
	logic                               analog_mode_q;
	logic [ADC_BITS-1:0]                adc_min_q;
	logic [ADC_BITS-1:0]                adc_max_q;
	logic                               reverse_q;
	logic [rces_pkg::EXPO_W-1:0]        expo_q;
	logic                               use_low_q;
	logic [rces_pkg::GAIN_W-1:0]        low_gain_q;
	logic [rces_pkg::GAIN_W-1:0]        high_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			analog_mode_q <= 1'b1;
			adc_min_q     <= '0;
			adc_max_q     <= ADC_BITS'(4095);
			reverse_q     <= 1'b0;
			expo_q        <= '0;
			use_low_q     <= 1'b0;
			low_gain_q    <= rces_pkg::GAIN_MIN;
			high_gain_q   <= rces_pkg::GAIN_MIN;
		end else if (cfg_write) begin
			unique case (rces_pkg::reg_idx_t'(cfg_index))
				rces_pkg::REG_ANALOG_MODE: analog_mode_q <= cfg_data[0];
				rces_pkg::REG_ADC_MIN:     adc_min_q     <= cfg_data[ADC_BITS-1:0];
				rces_pkg::REG_ADC_MAX:     adc_max_q     <= cfg_data[ADC_BITS-1:0];
				rces_pkg::REG_REVERSE_DIR: reverse_q     <= cfg_data[0];
				rces_pkg::REG_EXPO_PERCENT: begin
					expo_q <= (cfg_data[rces_pkg::EXPO_W-1:0] > rces_pkg::EXPO_CAP) ?
						rces_pkg::EXPO_CAP : cfg_data[rces_pkg::EXPO_W-1:0];
				end
				rces_pkg::REG_USE_LOW_RATE: use_low_q <= cfg_data[0];
				rces_pkg::REG_LOW_RATE_GAIN: begin
					if (cfg_data[rces_pkg::GAIN_W-1:0] >= rces_pkg::GAIN_MIN) begin
						low_gain_q <= cfg_data[rces_pkg::GAIN_W-1:0];
					end
				end
				rces_pkg::REG_HIGH_RATE_GAIN: begin
					if (cfg_data[rces_pkg::GAIN_W-1:0] >= rces_pkg::GAIN_MIN) begin
						high_gain_q <= cfg_data[rces_pkg::GAIN_W-1:0];
					end
				end
			endcase
		end
	end

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;
	logic en_s12;
	logic div_ready, div_valid;

	assign en_s12 = !v_s12 || result_ready;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || en_s9;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign en_s5  = !v_s5  || en_s6;
	assign en_s4  = !v_s4  || en_s5;
	assign en_s3  = !v_s3  || en_s4;
	assign en_s2  = !v_s2  || en_s3;
	assign en_s1  = !v_s1  || div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= sample_valid;
			if (en_s2)  v_s2  <= div_valid;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
		end
	end

	// s1: offsets from adc_min, span and map selection
	logic signed [ADC_BITS:0] diff, span;
	logic [ADC_BITS-1:0]      dabs_c, sabs_c;
	rces_pkg::map_tag_t       tag_c;
	logic [ADC_BITS-1:0]      dabs_s1, sabs_s1;
	rces_pkg::map_tag_t       tag_s1;

	assign diff = $signed({1'b0, sample}) - $signed({1'b0, adc_min_q});
	assign span = $signed({1'b0, adc_max_q}) - $signed({1'b0, adc_min_q});

	always_comb begin
		dabs_c = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
		sabs_c = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];
		tag_c.analog  = analog_mode_q;
		tag_c.reverse = reverse_q;
		if (!analog_mode_q) begin
			tag_c.sel = sample[0] ? rces_pkg::MAP_ONE : rces_pkg::MAP_ZERO;
		end else if (span == '0) begin
			tag_c.sel = (!diff[ADC_BITS] && (diff != '0)) ? rces_pkg::MAP_ONE :
				rces_pkg::MAP_MONE;
		end else if (diff[ADC_BITS] != span[ADC_BITS]) begin
			tag_c.sel = rces_pkg::MAP_MONE;
		end else begin
			tag_c.sel = rces_pkg::MAP_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dabs_s1 <= dabs_c;
			sabs_s1 <= sabs_c;
			tag_s1  <= tag_c;
		end
	end

	// divider: (4*|diff|*ONE + |span|) / (2*|span|)
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic [MW-1:0]       dquot;
	logic                dsat;
	rces_pkg::map_tag_t  dtag;

	assign div_num = NUM_W'({dabs_s1, {(FRAC_BITS+2){1'b0}}}) + NUM_W'(sabs_s1);
	assign div_den = {sabs_s1, 1'b0};

	rces_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.Q_W   (MW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (v_s1),
		.num_ready  (div_ready),
		.num        (div_num),
		.den        (div_den),
		.tag        (tag_s1),
		.quot_valid (div_valid),
		.quot_ready (en_s2),
		.quot       (dquot),
		.sat        (dsat),
		.quot_tag   (dtag)
	);

	// s2: raw and reversed value
	logic signed [OW-1:0] raw_c, rev_c;
	logic signed [OW-1:0] raw_s2, rev_s2;

	always_comb begin
		case (dtag.sel)
			rces_pkg::MAP_DIV:  raw_c = dsat ? Q_ONE : ($signed(OW'(dquot)) - Q_ONE);
			rces_pkg::MAP_ONE:  raw_c = Q_ONE;
			rces_pkg::MAP_MONE: raw_c = -Q_ONE;
			default:            raw_c = '0;
		endcase
		if (!dtag.reverse) begin
			rev_c = raw_c;
		end else if (dtag.analog) begin
			rev_c = -raw_c;
		end else begin
			rev_c = (raw_c >= Q_HALF) ? '0 : Q_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			raw_s2 <= raw_c;
			rev_s2 <= rev_c;
		end
	end

	// s3: magnitude and square
	logic [MW-1:0]        m_c;
	logic [MW-1:0]        m_s3;
	logic                 neg_s3;
	logic [2*MW-1:0]      sq_s3;
	logic signed [OW-1:0] raw_s3, rev_s3;

	assign m_c = rev_s2[OW-1] ? MW'(-rev_s2) : MW'(rev_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			m_s3   <= m_c;
			neg_s3 <= rev_s2[OW-1];
			sq_s3  <= m_c * m_c;
			raw_s3 <= raw_s2;
			rev_s3 <= rev_s2;
		end
	end

	// s4: round square, cube
	logic [2*MW-1:0]      sqr_c;
	logic [MW-1:0]        m_s4;
	logic                 neg_s4;
	logic [2*MW-1:0]      cu_s4;
	logic signed [OW-1:0] raw_s4, rev_s4;

	assign sqr_c = sq_s3 + RND_HALF;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			cu_s4  <= sqr_c[FRAC_BITS +: MW] * m_s3;
			raw_s4 <= raw_s3;
			rev_s4 <= rev_s3;
		end
	end

	// s5: expo weight times (cube - linear)
	logic [2*MW-1:0]        cur_c;
	logic signed [OW-1:0]   dlt_c;
	logic [MW-1:0]          m_s5;
	logic                   neg_s5;
	logic signed [ED_W-1:0] ed_s5;
	logic signed [OW-1:0]   raw_s5, rev_s5;

	assign cur_c = cu_s4 + RND_HALF;
	assign dlt_c = $signed(OW'(cur_c[FRAC_BITS +: MW])) - $signed(OW'(m_s4));

	always_ff @(posedge clk) begin
		if (en_s5) begin
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
			ed_s5  <= $signed({1'b0, expo_q}) * dlt_c;
			raw_s5 <= raw_s4;
			rev_s5 <= rev_s4;
		end
	end

	// s6: numerator 100*m + e*(m3-m) + 50
	logic signed [ED_W-1:0] m_ext, nsum_c;
	logic [ND_W-1:0]        num_s6;
	logic                   neg_s6;
	logic signed [OW-1:0]   raw_s6, rev_s6;

	assign m_ext  = $signed(ED_W'(m_s5));
	assign nsum_c = (m_ext <<< 6) + (m_ext <<< 5) + (m_ext <<< 2) + ed_s5 + ED_W'(50);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			num_s6 <= nsum_c[ND_W-1:0];
			neg_s6 <= neg_s5;
			raw_s6 <= raw_s5;
			rev_s6 <= rev_s5;
		end
	end

	// s7: reciprocal multiply for the divide by one hundred
	logic [PW-1:0]        prod_s7;
	logic [ND_W-1:0]      num_s7;
	logic                 neg_s7;
	logic signed [OW-1:0] raw_s7, rev_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			prod_s7 <= num_s6 * RECIP;
			num_s7  <= num_s6;
			neg_s7  <= neg_s6;
			raw_s7  <= raw_s6;
			rev_s7  <= rev_s6;
		end
	end

	// s8: estimate and remainder
	logic [MW-1:0]        q0_c;
	logic [ND_W-1:0]      r_c;
	logic [MW-1:0]        q0_s8;
	logic [7:0]           r_s8;
	logic                 neg_s8;
	logic signed [OW-1:0] raw_s8, rev_s8;

	assign q0_c = prod_s7[ND_W +: MW];
	assign r_c  = num_s7 - (ND_W'(q0_c) * ND_W'(100));

	always_ff @(posedge clk) begin
		if (en_s8) begin
			q0_s8  <= q0_c;
			r_s8   <= r_c[7:0];
			neg_s8 <= neg_s7;
			raw_s8 <= raw_s7;
			rev_s8 <= rev_s7;
		end
	end

	// s9: correct estimate, apply inverted sign
	logic [MW-1:0]        t_c;
	logic signed [OW-1:0] y_s9;
	logic signed [OW-1:0] raw_s9, rev_s9;

	assign t_c = (r_s8 >= 8'd100) ? (q0_s8 + MW'(1)) : q0_s8;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			y_s9   <= neg_s8 ? $signed(OW'(t_c)) : -$signed(OW'(t_c));
			raw_s9 <= raw_s8;
			rev_s9 <= rev_s8;
		end
	end

	// s10: rate gain
	logic [rces_pkg::GAIN_W-1:0] gain_c;
	logic signed [GP_W-1:0]      gp_s10;
	logic signed [OW-1:0]        raw_s10, rev_s10;

	assign gain_c = use_low_q ? low_gain_q : high_gain_q;

	always_ff @(posedge clk) begin
		if (en_s10) begin
			gp_s10  <= y_s9 * $signed({1'b0, gain_c});
			raw_s10 <= raw_s9;
			rev_s10 <= rev_s9;
		end
	end

	// s11: round magnitude to FRAC_BITS fraction bits (Q14 at the default)
	logic [GP_W-1:0]      mag_c, rsum_c;
	logic [RN_W-1:0]      rnd_s11;
	logic                 sgn_s11;
	logic signed [OW-1:0] raw_s11, rev_s11;

	assign mag_c  = gp_s10[GP_W-1] ? GP_W'(-gp_s10) : GP_W'(gp_s10);
	assign rsum_c = mag_c + GP_W'(128);

	always_ff @(posedge clk) begin
		if (en_s11) begin
			rnd_s11 <= rsum_c[8 +: RN_W];
			sgn_s11 <= gp_s10[GP_W-1];
			raw_s11 <= raw_s10;
			rev_s11 <= rev_s10;
		end
	end

	// s12: saturate, output register
	logic signed [OW-1:0] shaped_c;
	logic signed [OW-1:0] shaped_s12, raw_s12, rev_s12;

	always_comb begin
		if (sgn_s11) begin
			shaped_c = (rnd_s11 > RN_TWO) ? S_MIN : -$signed(OW'(rnd_s11));
		end else begin
			shaped_c = (rnd_s11 >= RN_TWO) ? S_MAX : $signed(OW'(rnd_s11));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s12) begin
			shaped_s12 <= shaped_c;
			raw_s12    <= raw_s11;
			rev_s12    <= rev_s11;
		end
	end

	assign sample_ready   = en_s1;
	assign result_valid   = v_s12;
	assign raw_value      = raw_s12;
	assign reversed_value = rev_s12;
	assign shaped_value   = shaped_s12;

	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (raw_value <= Q_ONE && raw_value >= -Q_ONE))
		else $error("raw value outside unit range");

	a_digital_level: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !analog_mode_q) |-> (raw_value == '0 || raw_value == Q_ONE))
		else $error("digital raw value not a level");

	a_analog_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && analog_mode_q && reverse_q) |-> (reversed_value == -raw_value))
		else $error("analog reversal not a negation");

	a_centre_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && reversed_value == '0) |-> (shaped_value == '0))
		else $error("centred stick gives non-zero output");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("input held off with empty output stage");

endmodule

// ===== dv/tb_rc_channel_expo_rate_shaper_top.sv =====
// Testbench for rc_channel_expo_rate_shaper_top: drives sample words, predicts the raw,
// reversed and shaped values in-bench and checks every result word in order.
// Depends on rces_pkg and the shaper RTL.
`timescale 1ns / 1ps

module tb_rc_channel_expo_rate_shaper_top;
	import rces_pkg::*;

	localparam int ADC_BITS     = 12;
	localparam int FRAC_BITS    = 14;
	localparam int VAL_W        = FRAC_BITS + 2;
	localparam int CFG_W        = (ADC_BITS > GAIN_W) ? ADC_BITS : GAIN_W;
	localparam longint ONE      = longint'(1) << FRAC_BITS;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 40;
	localparam int RX_HOLD_LEN  = 400;

	typedef struct {
		bit                 analog;
		bit [ADC_BITS-1:0]  amin;
		bit [ADC_BITS-1:0]  amax;
		bit                 rev_dir;
		bit [EXPO_W-1:0]    expo;
		bit                 low;
		bit [GAIN_W-1:0]    lgain;
		bit [GAIN_W-1:0]    hgain;
	} shaper_cfg_t;

	typedef struct {
		logic signed [VAL_W-1:0] raw;
		logic signed [VAL_W-1:0] rev;
		logic signed [VAL_W-1:0] shaped;
	} chan_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_ready;
	logic [ADC_BITS-1:0]        sample = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic signed [VAL_W-1:0]    raw_value;
	logic signed [VAL_W-1:0]    reversed_value;
	logic signed [VAL_W-1:0]    shaped_value;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	shaper_cfg_t                ch_cfg;
	logic [ADC_BITS-1:0]        samples_todo[$];
	chan_word_t                 words_due[$];
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	bit                         rx_hold_req = 1'b0;
	int                         rx_hold_left = 0;
	int                         fails = 0;
	int                         cycle_cnt = 0;

	rc_channel_expo_rate_shaper_top #(
		.ADC_BITS(ADC_BITS),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.raw_value(raw_value),
		.reversed_value(reversed_value),
		.shaped_value(shaped_value),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint div_near(longint num, longint den);
		longint n;
		longint d;
		longint q;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic chan_word_t shape_sample(shaper_cfg_t c, logic [ADC_BITS-1:0] s);
		longint diff;
		longint span;
		longint raw;
		longint rev;
		longint m;
		longint m2;
		longint m3;
		longint t;
		longint y;
		longint gain;
		longint sh;
		chan_word_t w;
		if (c.analog) begin
			diff = longint'(s) - longint'(c.amin);
			span = longint'(c.amax) - longint'(c.amin);
			if (span == 0)
				raw = (diff > 0) ? ONE : -ONE;
			else
				raw = clamp(div_near(diff * 2 * ONE, span) - ONE, -ONE, ONE);
		end else begin
			raw = s[0] ? ONE : 0;
		end
		rev = raw;
		if (c.rev_dir)
			rev = c.analog ? -raw : ((raw >= ONE / 2) ? 0 : ONE);
		m = (rev < 0) ? -rev : rev;
		m2 = (m * m + ONE / 2) >>> FRAC_BITS;
		m3 = (m2 * m + ONE / 2) >>> FRAC_BITS;
		t = (longint'(c.expo) * m3 + (100 - longint'(c.expo)) * m + 50) / 100;
		y = clamp((rev < 0) ? t : -t, -ONE, ONE);
		gain = c.low ? longint'(c.lgain) : longint'(c.hgain);
		sh = clamp(div_near(y * gain, 256), -2 * ONE, 2 * ONE - 1);
		w.raw = raw[VAL_W-1:0];
		w.rev = rev[VAL_W-1:0];
		w.shaped = sh[VAL_W-1:0];
		return w;
	endfunction

	task automatic set_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ANALOG_MODE:    ch_cfg.analog = data[0];
			REG_ADC_MIN:        ch_cfg.amin = data[ADC_BITS-1:0];
			REG_ADC_MAX:        ch_cfg.amax = data[ADC_BITS-1:0];
			REG_REVERSE_DIR:    ch_cfg.rev_dir = data[0];
			REG_EXPO_PERCENT:   ch_cfg.expo = (data[EXPO_W-1:0] > EXPO_CAP) ? EXPO_CAP
				: data[EXPO_W-1:0];
			REG_USE_LOW_RATE:   ch_cfg.low = data[0];
			REG_LOW_RATE_GAIN:  if (data[GAIN_W-1:0] >= GAIN_MIN) ch_cfg.lgain = data[GAIN_W-1:0];
			REG_HIGH_RATE_GAIN: if (data[GAIN_W-1:0] >= GAIN_MIN) ch_cfg.hgain = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (samples_todo.size() != 0 || words_due.size() != 0)
			@(posedge clk);
	endtask

	// sample driver: hold the word until taken, then offer the next one or idle
	always @(posedge clk) begin
		bit took;
		took = 1'b0;
		if (sample_valid && sample_ready) begin
			words_due.push_back(shape_sample(ch_cfg, samples_todo.pop_front()));
			took = 1'b1;
		end
		if (!sample_valid || took) begin
			if (arst_n && samples_todo.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				sample_valid <= 1'b1;
				sample <= samples_todo[0];
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		chan_word_t want;
		if (result_valid && result_ready) begin
			if (words_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected word raw %0d reversed %0d shaped %0d", $time,
					raw_value, reversed_value, shaped_value);
			end else begin
				want = words_due.pop_front();
				if (raw_value !== want.raw) begin
					fails++;
					$display("%0t: raw_value expected %0d actual %0d", $time, want.raw, raw_value);
				end
				if (reversed_value !== want.rev) begin
					fails++;
					$display("%0t: reversed_value expected %0d actual %0d", $time, want.rev,
						reversed_value);
				end
				if (shaped_value !== want.shaped) begin
					fails++;
					$display("%0t: shaped_value expected %0d actual %0d", $time, want.shaped,
						shaped_value);
				end
			end
		end
		if (rx_hold_req) begin
			rx_hold_left = RX_HOLD_LEN;
			rx_hold_req = 1'b0;
		end
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("rc_channel_expo_rate_shaper_top test failed");
		$finish;
	end

	initial begin
		int sent;
		int n;
		bit held;
		logic [ADC_BITS-1:0] lo_v;
		logic [ADC_BITS-1:0] hi_v;
		logic [ADC_BITS-1:0] s;
		logic [CFG_W-1:0] junk;
		logic [EXPO_W-1:0] ex;
		logic [GAIN_W-1:0] g;
		ch_cfg.analog = 1'b1;
		ch_cfg.amin = '0;
		ch_cfg.amax = '1;
		ch_cfg.rev_dir = 1'b0;
		ch_cfg.expo = '0;
		ch_cfg.low = 1'b0;
		ch_cfg.lgain = GAIN_MIN;
		ch_cfg.hgain = GAIN_MIN;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full span at reset settings: ends, midpoint and neighbours
		samples_todo = {12'd0, 12'd1, 12'd2047, 12'd2048, 12'd4094, 12'd4095};
		drain();
		// full expo, analog reverse, largest low rate gain
		set_reg(REG_EXPO_PERCENT, 12'd100);
		set_reg(REG_REVERSE_DIR, 12'd1);
		set_reg(REG_USE_LOW_RATE, 12'd1);
		set_reg(REG_LOW_RATE_GAIN, 12'd1023);
		samples_todo = {12'd0, 12'd4095, 12'd1024, 12'd3000};
		drain();
		// equal min and max
		set_reg(REG_ADC_MIN, 12'd2000);
		set_reg(REG_ADC_MAX, 12'd2000);
		samples_todo = {12'd1999, 12'd2000, 12'd2001};
		drain();
		// min above max, expo above a hundred, gain below one ignored
		set_reg(REG_ADC_MIN, 12'd3000);
		set_reg(REG_ADC_MAX, 12'd1000);
		set_reg(REG_EXPO_PERCENT, 12'd127);
		set_reg(REG_HIGH_RATE_GAIN, 12'd100);
		set_reg(REG_USE_LOW_RATE, 12'd0);
		samples_todo = {12'd0, 12'd2000, 12'd4095};
		drain();
		// digital mode, upper sample bits ignored
		set_reg(REG_ANALOG_MODE, 12'd0);
		set_reg(REG_REVERSE_DIR, 12'd0);
		samples_todo = {12'd0, 12'd1, 12'd4094, 12'd4095};
		drain();
		set_reg(REG_REVERSE_DIR, 12'd1);
		samples_todo = {12'd0, 12'd1};
		drain();

		sent = 0;
		held = 1'b0;
		while (sent < 1900) begin
			if (sent < 630) begin
				send_idle_pct = 17;
				recv_idle_pct = 50;
			end else if (sent < 1260) begin
				send_idle_pct = 50;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			junk = CFG_W'($urandom);
			set_reg(REG_ANALOG_MODE, {junk[CFG_W-1:1], 1'($urandom_range(0, 4) != 0)});
			case ($urandom_range(0, 5))
				0: begin lo_v = '0; hi_v = '1; end
				1: begin lo_v = '1; hi_v = '0; end
				2: begin lo_v = ADC_BITS'($urandom); hi_v = lo_v; end
				3: begin
					lo_v = ADC_BITS'($urandom_range(0, 3000));
					hi_v = lo_v + ADC_BITS'($urandom_range(1, 8));
				end
				default: begin lo_v = ADC_BITS'($urandom); hi_v = ADC_BITS'($urandom); end
			endcase
			set_reg(REG_ADC_MIN, lo_v);
			set_reg(REG_ADC_MAX, hi_v);
			junk = CFG_W'($urandom);
			set_reg(REG_REVERSE_DIR, junk);
			case ($urandom_range(0, 4))
				0: ex = '0;
				1: ex = EXPO_CAP;
				2: ex = EXPO_W'($urandom_range(101, 127));
				default: ex = EXPO_W'($urandom_range(0, 100));
			endcase
			junk = CFG_W'($urandom);
			set_reg(REG_EXPO_PERCENT, {junk[CFG_W-1:EXPO_W], ex});
			junk = CFG_W'($urandom);
			set_reg(REG_USE_LOW_RATE, junk);
			for (int k = 0; k < 2; k++) begin
				case ($urandom_range(0, 3))
					0: g = GAIN_MIN;
					1: g = '1;
					2: g = GAIN_W'($urandom_range(0, 255));
					default: g = GAIN_W'($urandom_range(256, 1023));
				endcase
				junk = CFG_W'($urandom);
				set_reg(k ? REG_HIGH_RATE_GAIN : REG_LOW_RATE_GAIN, {junk[CFG_W-1:GAIN_W], g});
			end

			n = int'($urandom_range(30, 90));
			// stall the receiver long enough to back the pipeline up into the input
			if (!held && sent >= 900) begin
				held = 1'b1;
				n = 150;
				rx_hold_req = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 7))
					0: s = $urandom_range(0, 1) ? '1 : '0;
					1: s = lo_v + ADC_BITS'($urandom_range(0, 6)) - ADC_BITS'(3);
					2: s = hi_v + ADC_BITS'($urandom_range(0, 6)) - ADC_BITS'(3);
					default: s = ADC_BITS'($urandom);
				endcase
				samples_todo.push_back(s);
			end
			drain();
			sent += n;
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		if (fails == 0 && words_due.size() == 0) begin
			$display("rc_channel_expo_rate_shaper_top test passed");
		end else begin
			$display("rc_channel_expo_rate_shaper_top test failed");
		end
		$finish;
	end

endmodule
